/* hw/rtl/circular_deque_top_assert.svh */
// Assertion macros for the circular deque checker.
// Used by the checker file; relies on clk and arst_n being in scope.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular deque check failed");

`endif

/* hw/rtl/cdq_pkg.sv */
// Shared types, constants and helper functions for the circular deque.
// No dependencies; imported by cdq_cfg, cdq_ctrl, cdq_resp, the top level and the checker.
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int DEPTH      = 128;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CAP_W      = 8;
	localparam int ADDR_W     = 3;
	localparam int PDATA_W    = 32;
	localparam int USER_IN_W  = 8;
	localparam int USER_OUT_W = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

	localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_FRONT = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic    rd;
		status_t status;
		logic    full;
		logic    empty;
	} resp_ctl_t;

	function automatic logic [IDX_W-1:0] cap_last_of(input logic [CAP_W-1:0] raw);
		int c;
		c = int'(raw);
		if (c == 0) begin
			c = 1;
		end
		if (c > DEPTH) begin
			c = DEPTH;
		end
		return IDX_W'(c - 1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i,
		input logic [IDX_W-1:0] last);
		return (i == last) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i,
		input logic [IDX_W-1:0] last);
		return (i == '0) ? last : i - IDX_W'(1);
	endfunction

endpackage

/* hw/rtl/cdq_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cdq_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* hw/rtl/cdq_cfg.sv */
// APB-style configuration register block holding the deque capacity.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]   paddr,
	input  logic [cdq_pkg::PDATA_W-1:0]  pwdata,
	output logic [cdq_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic                         cfg_wr,
	output logic [cdq_pkg::IDX_W-1:0]    cap_last
);

	import cdq_pkg::*;

	logic [CAP_W-1:0] cap_raw_q;
	logic [IDX_W-1:0] cap_last_q;
	logic             hit;

	assign hit      = (paddr[ADDR_W-1:2] == REG_CAPACITY);
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && hit;
	assign cap_last = cap_last_q;
	assign prdata   = hit ? PDATA_W'(cap_raw_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_raw_q  <= CAP_RESET;
			cap_last_q <= cap_last_of(CAP_RESET);
		end else if (cfg_wr) begin
			cap_raw_q  <= pwdata[CAP_W-1:0];
			cap_last_q <= cap_last_of(pwdata[CAP_W-1:0]);
		end
	end

endmodule

/* hw/rtl/cdq_ctrl.sv */
// Deque index control: head, tail and empty state, ring access decode.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  cdq_pkg::op_t                    op,
	input  logic [cdq_pkg::DATA_WIDTH-1:0]  value,
	input  logic                            cfg_wr,
	input  logic [cdq_pkg::IDX_W-1:0]       cap_last,
	output logic                            ram_en,
	output logic                            ram_we,
	output logic [cdq_pkg::IDX_W-1:0]       ram_addr,
	output logic [cdq_pkg::DATA_WIDTH-1:0]  ram_wdata,
	output cdq_pkg::resp_ctl_t              ctl
);

	import cdq_pkg::*;

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d, addr;
	logic             empty_q, empty_d, we, rd, is_push, full_now;
	status_t          status;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		status   = ST_DONE;
		rd       = 1'b0;
		we       = 1'b0;
		addr     = head_q;
		is_push  = (op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT);
		full_now = !empty_q && (head_q == idx_inc(tail_q, cap_last));
		if (is_push) begin
			if (full_now) begin
				status = ST_FULL;
			end else if (empty_q) begin
				head_d  = '0;
				tail_d  = '0;
				empty_d = 1'b0;
				we      = 1'b1;
				addr    = '0;
			end else if (op == OP_PUSH_BACK) begin
				tail_d = idx_inc(tail_q, cap_last);
				we     = 1'b1;
				addr   = tail_d;
			end else begin
				head_d = idx_dec(head_q, cap_last);
				we     = 1'b1;
				addr   = head_d;
			end
		end else begin
			if (empty_q) begin
				status = ST_EMPTY;
			end else begin
				rd   = 1'b1;
				addr = (op == OP_POP_FRONT) ? head_q : tail_q;
				if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else if (op == OP_POP_FRONT) begin
					head_d = idx_inc(head_q, cap_last);
				end else begin
					tail_d = idx_dec(tail_q, cap_last);
				end
			end
		end
	end

	assign ram_en     = accept && (we || rd);
	assign ram_we     = accept && we;
	assign ram_addr   = addr;
	assign ram_wdata  = value;
	assign ctl.rd     = rd;
	assign ctl.status = status;
	assign ctl.full   = !empty_d && (head_d == idx_inc(tail_d, cap_last));
	assign ctl.empty  = empty_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_wr) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

endmodule

/* hw/rtl/cdq_resp.sv */
// Result path: read stage waiting on RAM data, then the output register.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_resp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  cdq_pkg::resp_ctl_t                ctl,
	input  logic [cdq_pkg::DATA_WIDTH-1:0]    rdata,
	output logic                              in_ready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cdq_pkg::DATA_WIDTH-1:0]    m_tdata,
	output logic [cdq_pkg::USER_OUT_W-1:0]    m_tuser
);

	import cdq_pkg::*;

	logic      v_s1, out_valid_q, advance;
	resp_ctl_t ctl_s1;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic [USER_OUT_W-1:0] out_user_q;

	assign advance  = v_s1 && (!out_valid_q || m_tready);
	assign in_ready = !v_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
		end
		if (advance) begin
			out_data_q <= ctl_s1.rd ? rdata : '0;
			out_user_q <= USER_OUT_W'({ctl_s1.empty, ctl_s1.full, ctl_s1.status});
		end
	end

endmodule

/* hw/rtl/circular_deque_top.sv */
// Top level of the circular deque: config block, index control, ring RAM, result path.
// Depends on cdq_pkg, cdq_cfg, cdq_ctrl, cdq_ram and cdq_resp.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                    Contents
// s_*       in         s_tvalid / s_tready          one operation word
// m_*       out        m_tvalid / m_tready          one result word per operation
// apb       in/out     psel, penable, pwrite        capacity register at address 0
//
// An operation is accepted into the read stage, and its result moves on to the output
// register; the ring RAM's registered read port sets that depth. The single RAM port serves
// one read or one write per word, so one word is accepted per cycle when m_tready is
// high. A pending result stalls intake only once the read stage is also occupied.
// Reset empties the deque and sets the capacity to 128; ring contents are not cleared.

module circular_deque_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cdq_pkg::DATA_WIDTH-1:0]    s_tdata,  // [31:0] value
	input  logic [cdq_pkg::USER_IN_W-1:0]     s_tuser,  // [1:0] op, [7:2] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cdq_pkg::DATA_WIDTH-1:0]    m_tdata,  // [31:0] popped_value
	output logic [cdq_pkg::USER_OUT_W-1:0]    m_tuser,  // [1:0] status, [2] is_full,
	                                                    // [3] is_empty, [7:4] zero
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]        paddr,
	input  logic [cdq_pkg::PDATA_W-1:0]       pwdata,
	output logic [cdq_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	import cdq_pkg::*;

	logic                  accept, in_ready, cfg_wr;
	logic                  ram_en, ram_we;
	logic [IDX_W-1:0]      cap_last, ram_addr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
	resp_ctl_t             ctl;

	assign s_tready = in_ready;
	assign accept   = s_tvalid && in_ready;

	cdq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg_wr   (cfg_wr),
		.cap_last (cap_last)
	);

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op_t'(s_tuser[1:0])),
		.value     (s_tdata),
		.cfg_wr    (cfg_wr),
		.cap_last  (cap_last),
		.ram_en    (ram_en),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ctl       (ctl)
	);

	cdq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cdq_resp u_resp (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ctl      (ctl),
		.rdata    (ram_rdata),
		.in_ready (in_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* hw/rtl/cdq_checker.sv */
// Port-level checks on the circular deque results, bound to the top level.
// Depends on cdq_pkg and circular_deque_top_assert.svh.
`timescale 1ns / 1ps
`include "circular_deque_top_assert.svh"

module cdq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cdq_pkg::DATA_WIDTH-1:0]    m_tdata,
	input logic [cdq_pkg::USER_OUT_W-1:0]    m_tuser
);

	import cdq_pkg::*;

	// A stalled result word holds until it is taken.
	`CDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// The deque cannot be full and empty at once.
	`CDQ_ASSERT_NOW(a_flags_excl, m_tvalid, !(m_tuser[2] && m_tuser[3]))

	// A refused push means the deque stayed full and no value was popped.
	`CDQ_ASSERT_NOW(a_full_reject, m_tvalid && (m_tuser[1:0] == ST_FULL),
		m_tuser[2] && (m_tdata == '0))

	// A refused pop means the deque stayed empty and no value was popped.
	`CDQ_ASSERT_NOW(a_empty_reject, m_tvalid && (m_tuser[1:0] == ST_EMPTY),
		m_tuser[3] && (m_tdata == '0))

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);
